>>> rtl/bttp_pkg.sv
// shared types and constants for the batch timestamp phase tracker
// no dependencies; used by every rtl file of the block
`default_nettype none

package bttp_pkg;

  localparam int TIME_W   = 64;
  localparam int CAP_W    = 63;
  localparam int CNT_W    = 6;
  localparam int PERIOD_W = 17;
  localparam int WIN_W    = 20;
  localparam int SLEW_W   = 17;
  localparam int ERR_W    = 32;
  localparam int PROD_W   = CNT_W + PERIOD_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = WIN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW   = 3'd3;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 17'd1000;
  localparam logic [WIN_W-1:0]    SOFT_RST   = 20'd2000;
  localparam logic [WIN_W-1:0]    HARD_RST   = 20'd20000;
  localparam logic [SLEW_W-1:0]   SLEW_RST   = 17'd200;

  localparam logic [ERR_W-1:0] ERR_SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [ERR_W-1:0] ERR_SAT_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_HARD  = 2'd1,
    MODE_SOFT  = 2'd2,
    MODE_COAST = 2'd3
  } lock_mode_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [WIN_W-1:0]    soft_window_us;
    logic [WIN_W-1:0]    hard_resync_us;
    logic [SLEW_W-1:0]   max_slew_us;
  } cfg_t;

  // precomputed terms handed from the front stages to the tracking stage
  typedef struct packed {
    logic [TIME_W-1:0] measured;
    logic [TIME_W-1:0] meas_next;
    logic [TIME_W-1:0] step;
    logic [TIME_W-1:0] step_up;
    logic [TIME_W-1:0] step_dn;
  } front_t;

endpackage

`default_nettype wire

>>> rtl/bttp_batch_if.sv
// request channel carrying one drained sensor batch
// depends on bttp_pkg for field widths
`default_nettype none

interface bttp_batch_if;
  logic                              valid;
  logic                              ready;
  logic [bttp_pkg::CAP_W-1:0]        cap_time;
  logic [bttp_pkg::CNT_W-1:0]        batch_count;

  modport source (output valid, cap_time, batch_count, input ready);
  modport sink (input valid, cap_time, batch_count, output ready);
endinterface

`default_nettype wire

>>> rtl/bttp_stamp_if.sv
// result channel carrying the assigned batch timestamp
// depends on bttp_pkg for field widths and the lock mode type
`default_nettype none

interface bttp_stamp_if;
  logic                              valid;
  logic                              ready;
  logic [bttp_pkg::CAP_W-1:0]        base_time_us;
  bttp_pkg::lock_mode_t              lock_mode;
  logic signed [bttp_pkg::ERR_W-1:0] phase_err;

  modport source (output valid, base_time_us, lock_mode, phase_err, input ready);
  modport sink (input valid, base_time_us, lock_mode, phase_err, output ready);
endinterface

`default_nettype wire

>>> rtl/bttp_cfg.sv
// configuration register file: period, soft window, hard threshold, slew limit
// depends on bttp_pkg
`default_nettype none

module bttp_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [bttp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bttp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  output bttp_pkg::cfg_t                       cfg
);
  import bttp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period         <= PERIOD_RST;
      cfg.soft_window_us <= SOFT_RST;
      cfg.hard_resync_us <= HARD_RST;
      cfg.max_slew_us    <= SLEW_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PERIOD: cfg.period         <= cfg_wr_data[PERIOD_W-1:0];
        CFG_SOFT:   cfg.soft_window_us <= cfg_wr_data[WIN_W-1:0];
        CFG_HARD:   cfg.hard_resync_us <= cfg_wr_data[WIN_W-1:0];
        CFG_SLEW:   cfg.max_slew_us    <= cfg_wr_data[SLEW_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/bttp_front.sv
// three front stages: count clamp, period products, measured base and step terms
// depends on bttp_pkg; feeds bttp_track
`default_nettype none

module bttp_front #(
  parameter int MAX_BATCH = 60
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bttp_pkg::cfg_t             cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [bttp_pkg::CAP_W-1:0] cap_time,
  input  wire logic [bttp_pkg::CNT_W-1:0] batch_count,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output bttp_pkg::front_t                out_data
);
  import bttp_pkg::*;

  localparam int CntMax = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] MaxCnt =
    (MAX_BATCH > CntMax) ? CNT_W'(CntMax) : CNT_W'(MAX_BATCH);

  logic             v1, v2;
  logic             rdy1, rdy2, rdy3;
  logic [CAP_W-1:0] cap1, cap2;
  logic [CNT_W-1:0] cnt1, cnt_next;
  logic [PROD_W-1:0] prod_m, prod_c;
  logic [PROD_W-1:0] prod_m_next, prod_c_next;
  front_t           front_next;

  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    priority if (batch_count == '0) begin
      cnt_next = CNT_W'(1);
    end else if (batch_count > MaxCnt) begin
      cnt_next = MaxCnt;
    end else begin
      cnt_next = batch_count;
    end
  end

  assign prod_m_next = PROD_W'(cnt1 - CNT_W'(1)) * PROD_W'(cfg.period);
  assign prod_c_next = PROD_W'(cnt1) * PROD_W'(cfg.period);

  // next prediction on adoption is capture + period since count*p - (count-1)*p = p
  always_comb begin
    front_next.measured  = {1'b0, cap2} - TIME_W'(prod_m);
    front_next.meas_next = {1'b0, cap2} + TIME_W'(cfg.period);
    front_next.step      = TIME_W'(prod_c);
    front_next.step_up   = TIME_W'(prod_c) + TIME_W'(cfg.max_slew_us);
    front_next.step_dn   = TIME_W'(prod_c) - TIME_W'(cfg.max_slew_us);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      cap1 <= cap_time;
      cnt1 <= cnt_next;
    end
    if (rdy2) begin
      cap2   <= cap1;
      prod_m <= prod_m_next;
      prod_c <= prod_c_next;
    end
    if (rdy3) begin
      out_data <= front_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bttp_track.sv
// tracking stage: lock flag, predicted base, mode decision and result register
// depends on bttp_pkg; fed by bttp_front
`default_nettype none

module bttp_track (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bttp_pkg::cfg_t       cfg,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire bttp_pkg::front_t     in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [bttp_pkg::CAP_W-1:0] base_time_us,
  output bttp_pkg::lock_mode_t      lock_mode,
  output logic [bttp_pkg::ERR_W-1:0] phase_err
);
  import bttp_pkg::*;

  logic              lock_valid;
  logic [TIME_W-1:0] predicted_base_us, predicted_base_us_next;
  logic [TIME_W-1:0] err_p, err_n, mag;
  logic [TIME_W-1:0] base_next;
  logic [ERR_W-1:0]  err_sat;
  lock_mode_t        mode_next;
  logic              neg, fire;
  logic              hit_hard, in_soft, in_slew;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  assign err_p    = in_data.measured - predicted_base_us;
  assign err_n    = predicted_base_us - in_data.measured;
  assign neg      = err_p[TIME_W-1];
  assign mag      = neg ? err_n : err_p;
  assign hit_hard = mag >= TIME_W'(cfg.hard_resync_us);
  assign in_soft  = mag <= TIME_W'(cfg.soft_window_us);
  assign in_slew  = mag <= TIME_W'(cfg.max_slew_us);

  always_comb begin
    if (err_p[TIME_W-1:ERR_W-1] == '0 || err_p[TIME_W-1:ERR_W-1] == '1) begin
      err_sat = err_p[ERR_W-1:0];
    end else begin
      err_sat = neg ? ERR_SAT_MIN : ERR_SAT_MAX;
    end
  end

  // a clamped correction that covers the whole error lands on the measured base
  always_comb begin
    priority if (!lock_valid) begin
      mode_next              = MODE_FIRST;
      base_next              = in_data.measured;
      predicted_base_us_next = in_data.meas_next;
    end else if (hit_hard) begin
      mode_next              = MODE_HARD;
      base_next              = in_data.measured;
      predicted_base_us_next = in_data.meas_next;
    end else if (in_soft && in_slew) begin
      mode_next              = MODE_SOFT;
      base_next              = in_data.measured;
      predicted_base_us_next = in_data.meas_next;
    end else if (in_soft && neg) begin
      mode_next              = MODE_SOFT;
      base_next              = predicted_base_us - TIME_W'(cfg.max_slew_us);
      predicted_base_us_next = predicted_base_us + in_data.step_dn;
    end else if (in_soft) begin
      mode_next              = MODE_SOFT;
      base_next              = predicted_base_us + TIME_W'(cfg.max_slew_us);
      predicted_base_us_next = predicted_base_us + in_data.step_up;
    end else begin
      mode_next              = MODE_COAST;
      base_next              = predicted_base_us;
      predicted_base_us_next = predicted_base_us + in_data.step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_valid        <= 1'b0;
      predicted_base_us <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        lock_valid        <= 1'b1;
        predicted_base_us <= predicted_base_us_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      base_time_us <= base_next[CAP_W-1:0];
      lock_mode    <= mode_next;
      phase_err    <= lock_valid ? err_sat : '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/batch_timestamp_phase_tracker.sv
// top level of the batch timestamp phase tracker
// depends on bttp_pkg, bttp_batch_if, bttp_stamp_if, bttp_cfg, bttp_front, bttp_track
`default_nettype none

// Assigns a first-sample timestamp to each sensor batch request and tracks the
// phase of the batch stream against its own prediction. One result comes out
// per request, in order. A request can be taken every clock cycle while the
// output is not stalled. The throughput is set by the tracking stage, whose
// prediction update (one 64-bit difference, a threshold compare and a select
// among precomputed sums) is combinational. Three front stages clamp the
// count, form the period products and precompute the measured base and the
// prediction step terms. Each stage holds its item while the next is full,
// so requests are still taken while a finished result waits. Configuration
// is written through cfg_wr_en, cfg_index and cfg_wr_data; the user must
// write it only while idle, and the block itself does not enforce this.

module batch_timestamp_phase_tracker #(
  parameter int MAX_BATCH = 60
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  bttp_batch_if.sink                           batch,
  bttp_stamp_if.source                         stamp,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bttp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bttp_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import bttp_pkg::*;

  cfg_t   cfg;
  front_t front_data;
  logic   front_valid, front_ready;

  bttp_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  bttp_front #(
    .MAX_BATCH (MAX_BATCH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (batch.valid),
    .in_ready    (batch.ready),
    .cap_time    (batch.cap_time),
    .batch_count (batch.batch_count),
    .out_valid   (front_valid),
    .out_ready   (front_ready),
    .out_data    (front_data)
  );

  bttp_track u_track (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (front_valid),
    .in_ready     (front_ready),
    .in_data      (front_data),
    .out_valid    (stamp.valid),
    .out_ready    (stamp.ready),
    .base_time_us (stamp.base_time_us),
    .lock_mode    (stamp.lock_mode),
    .phase_err    (stamp.phase_err)
  );

endmodule

`default_nettype wire

>>> rtl/bttp_checker.sv
// port-level checker for the batch timestamp phase tracker, bound to the top level
// depends on bttp_pkg
`default_nettype none

module bttp_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        batch_valid,
  input wire logic                        batch_ready,
  input wire logic                        stamp_valid,
  input wire logic                        stamp_ready,
  input wire logic [bttp_pkg::CAP_W-1:0]  base_time_us,
  input wire bttp_pkg::lock_mode_t        lock_mode,
  input wire logic [bttp_pkg::ERR_W-1:0]  phase_err
);
  import bttp_pkg::*;

  logic [2:0] pending;
  logic       first_done;
  logic       in_acc, out_acc;

  assign in_acc  = batch_valid && batch_ready;
  assign out_acc = stamp_valid && stamp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      first_done <= 1'b0;
    end else begin
      pending <= pending + 3'(in_acc) - 3'(out_acc);
      if (out_acc) begin
        first_done <= 1'b1;
      end
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stamp_valid && !stamp_ready |=> stamp_valid && $stable(base_time_us)
      && $stable(lock_mode) && $stable(phase_err))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    stamp_valid |-> pending != 3'd0)
    else $error("result without a pending request");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending == 3'd4 |-> !batch_ready || out_acc)
    else $error("more requests in flight than pipeline stages");

  a_first_lock: assert property (@(posedge clk) disable iff (rst)
    out_acc && !first_done |-> lock_mode == MODE_FIRST
      && phase_err == '0)
    else $error("first result is not a first lock");

  a_single_lock: assert property (@(posedge clk) disable iff (rst)
    out_acc && first_done |-> lock_mode != MODE_FIRST)
    else $error("first lock reported twice");

endmodule

bind batch_timestamp_phase_tracker bttp_checker u_bttp_checker (
  .clk          (clk),
  .rst          (rst),
  .batch_valid  (batch.valid),
  .batch_ready  (batch.ready),
  .stamp_valid  (stamp.valid),
  .stamp_ready  (stamp.ready),
  .base_time_us (stamp.base_time_us),
  .lock_mode    (stamp.lock_mode),
  .phase_err    (stamp.phase_err)
);

`default_nettype wire

>>> verif/testbench.sv
// self-checking bench for batch_timestamp_phase_tracker: directed, register, stall and random
// predicts each stamp with its own phase tracker; uses bttp_pkg, bttp_batch_if, bttp_stamp_if
`timescale 1ns / 1ps

module testbench;
  import bttp_pkg::*;

  localparam int MAX_BATCH = 60;
  localparam int LATENCY = 4;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_BATCHES = 570;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_SLEW + 1'b1;

  typedef struct packed {
    logic [CAP_W-1:0]        base;
    lock_mode_t              mode;
    logic signed [ERR_W-1:0] err;
  } batch_stamp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  bttp_batch_if batch_ch ();
  bttp_stamp_if stamp_ch ();

  batch_timestamp_phase_tracker #(
    .MAX_BATCH(MAX_BATCH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .batch(batch_ch),
    .stamp(stamp_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  // tracker copy
  logic [PERIOD_W-1:0] period_r = PERIOD_RST;
  logic [WIN_W-1:0] soft_r = SOFT_RST;
  logic [WIN_W-1:0] hard_r = HARD_RST;
  logic [SLEW_W-1:0] slew_r = SLEW_RST;
  logic tracker_locked = 1'b0;
  logic [TIME_W-1:0] tracker_next_base = '0;

  batch_stamp_t pending_stamps[$];
  int fail_count = 0;
  int requests_sent = 0;
  int stamps_checked = 0;
  int mode_seen[4] = '{0, 0, 0, 0};
  int stuck_cycles = 0;
  int hold_off_cycles = 0;
  bit no_gaps = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    batch_ch.valid = 1'b0;
    batch_ch.cap_time = '0;
    batch_ch.batch_count = '0;
  end

  function automatic logic [TIME_W-1:0] clamp_count(input logic [CNT_W-1:0] cnt);
    if (cnt == 0) begin
      return TIME_W'(1);
    end else if (cnt > MAX_BATCH) begin
      return TIME_W'(MAX_BATCH);
    end
    return TIME_W'(cnt);
  endfunction

  function automatic batch_stamp_t track_batch(input logic [CAP_W-1:0] cap,
                                               input logic [CNT_W-1:0] cnt);
    batch_stamp_t s;
    logic [TIME_W-1:0] n, p, meas, err, mag, corr, base;
    n = clamp_count(cnt);
    p = TIME_W'(period_r);
    meas = {1'b0, cap} - (n - 1) * p;
    err = meas - tracker_next_base;
    mag = err[TIME_W-1] ? -err : err;
    if (!tracker_locked) begin
      base = meas;
      s.mode = MODE_FIRST;
      s.err = '0;
      tracker_locked = 1'b1;
    end else begin
      if (!err[TIME_W-1]) begin
        s.err = (err > 64'h0000_0000_7FFF_FFFF) ? ERR_SAT_MAX : err[ERR_W-1:0];
      end else begin
        s.err = (err < 64'hFFFF_FFFF_8000_0000) ? ERR_SAT_MIN : err[ERR_W-1:0];
      end
      if (mag >= TIME_W'(hard_r)) begin
        base = meas;
        s.mode = MODE_HARD;
      end else if (mag <= TIME_W'(soft_r)) begin
        corr = (mag > TIME_W'(slew_r)) ? TIME_W'(slew_r) : mag;
        base = err[TIME_W-1] ? tracker_next_base - corr : tracker_next_base + corr;
        s.mode = MODE_SOFT;
      end else begin
        base = tracker_next_base;
        s.mode = MODE_COAST;
      end
    end
    tracker_next_base = base + n * p;
    s.base = base[CAP_W-1:0];
    return s;
  endfunction

  // capture time whose measured base lands at prediction plus offset
  function automatic logic [CAP_W-1:0] capture_for(input logic [CNT_W-1:0] cnt,
                                                   input logic [TIME_W-1:0] offset);
    logic [TIME_W-1:0] t;
    t = tracker_next_base + (clamp_count(cnt) - 1) * TIME_W'(period_r) + offset;
    return t[CAP_W-1:0];
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
    end
  endtask

  task automatic send_batch(input logic [CAP_W-1:0] cap, input logic [CNT_W-1:0] cnt);
    int gap;
    @(negedge clk);
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      batch_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    batch_ch.valid = 1'b1;
    batch_ch.cap_time = cap;
    batch_ch.batch_count = cnt;
    do @(posedge clk); while (!batch_ch.ready);
    pending_stamps.push_back(track_batch(cap, cnt));
    requests_sent++;
  endtask

  task automatic send_random_batch();
    logic [CNT_W-1:0] cnt;
    logic [TIME_W-1:0] mag;
    logic [CAP_W-1:0] cap;
    cnt = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(1, MAX_BATCH));
    case ($urandom_range(0, 9))
      0: mag = TIME_W'($urandom_range(0, slew_r));
      1, 2: mag = TIME_W'($urandom_range(0, soft_r));
      3, 4: mag = TIME_W'($urandom_range(soft_r, hard_r));
      5: mag = TIME_W'(hard_r) + TIME_W'($urandom_range(0, 100000));
      6: mag = {$urandom, $urandom};
      7: mag = '0;
      default: mag = TIME_W'($urandom_range(0, hard_r + 1000));
    endcase
    cap = capture_for(cnt, $urandom_range(0, 1) ? -mag : mag);
    if ($urandom_range(0, 9) == 0) begin
      cnt = CNT_W'($urandom);
      cap = CAP_W'({$urandom, $urandom});
    end
    send_batch(cap, cnt);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    batch_ch.valid = 1'b0;
    while (pending_stamps.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wr_data = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_PERIOD: period_r = data[PERIOD_W-1:0];
      CFG_SOFT: soft_r = data[WIN_W-1:0];
      CFG_HARD: hard_r = data[WIN_W-1:0];
      CFG_SLEW: slew_r = data[SLEW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input logic [CFG_DATA_W-1:0] period,
                             input logic [CFG_DATA_W-1:0] soft_win,
                             input logic [CFG_DATA_W-1:0] hard,
                             input logic [CFG_DATA_W-1:0] slew);
    wait_idle();
    write_reg(CFG_PERIOD, period);
    write_reg(CFG_SOFT, soft_win);
    write_reg(CFG_HARD, hard);
    write_reg(CFG_SLEW, slew);
    // spare indexes must leave every register alone
    write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, 2 ** CFG_IDX_W - 1)),
              CFG_DATA_W'($urandom));
  endtask

  task automatic test_first_lock_and_wrap();
    send_batch('0, 6'd1);
    send_batch(capture_for(6'd1, 64'd0), 6'd1);
    send_batch(capture_for(6'd0, 64'd150), 6'd0);
    send_batch(capture_for(6'd60, 64'd1500), 6'd60);
    send_batch(capture_for(6'd61, -64'd1500), 6'd61);
    send_batch(capture_for(6'd63, 64'd5000), 6'd63);
    send_batch(capture_for(6'd10, -64'd5000), 6'd10);
    send_batch(capture_for(6'd5, 64'd20000), 6'd5);
    send_batch(capture_for(6'd5, -64'd20000), 6'd5);
    send_batch(capture_for(6'd5, 64'd2000), 6'd5);
    send_batch(capture_for(6'd5, -64'd2001), 6'd5);
    send_batch(capture_for(6'd5, 64'd19999), 6'd5);
    send_batch(capture_for(6'd1, 64'h7FFF_FFFF), 6'd1);
    send_batch(capture_for(6'd1, 64'h8000_0000), 6'd1);
    send_batch(capture_for(6'd1, -64'h8000_0000), 6'd1);
    send_batch(capture_for(6'd1, -64'h8000_0001), 6'd1);
    send_batch({CAP_W{1'b1}}, 6'd60);
    send_batch('0, 6'd60);
    send_batch(capture_for(6'd1, 64'd0), 6'd1);
    send_batch({CAP_W{1'b1}}, 6'd1);
    // prediction now above 2^63: error of exactly -2^63
    send_batch(capture_for(6'd1, 64'h8000_0000_0000_0000), 6'd1);
    send_batch(capture_for(6'd2, 64'd0), 6'd2);
  endtask

  task automatic test_register_extremes();
    logic [CFG_DATA_W-1:0] setups [8][4];
    setups = '{
      '{20'd0, 20'd2000, 20'd20000, 20'd200},
      '{20'd100000, 20'd0, 20'd0, 20'd0},
      '{20'd1000, 20'd1000000, 20'd1000000, 20'd100000},
      '{20'd1, 20'hFFFFF, 20'hFFFFF, 20'h1FFFF},
      '{20'd100000, 20'd0, 20'd1000000, 20'd0},
      '{20'hFFFFF, 20'd500000, 20'd1000, 20'd0},
      '{20'h1FFFF, 20'd500000, 20'hFFFFF, 20'd100000},
      '{20'd1000, 20'd2000, 20'd20000, 20'd200}
    };
    foreach (setups[k]) begin
      apply_setup(setups[k][0], setups[k][1], setups[k][2], setups[k][3]);
      repeat (15) send_random_batch();
    end
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    no_gaps = 1'b1;
    hold_off_cycles = 300;
    repeat (40) send_random_batch();
    no_gaps = 1'b0;
  endtask

  task automatic test_random_batches();
    logic [CFG_DATA_W-1:0] period, soft_win, hard, slew;
    for (int i = 0; i < RANDOM_BATCHES; i++) begin
      if (i % 125 == 0) begin
        case ($urandom_range(0, 9))
          0: period = 20'd1000;
          1: period = 20'd100000;
          2: period = '0;
          3: period = CFG_DATA_W'($urandom);
          default: period = CFG_DATA_W'($urandom_range(1000, 100000));
        endcase
        soft_win = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 1000000))
                                               : CFG_DATA_W'($urandom_range(0, 50000));
        hard = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                           : CFG_DATA_W'(soft_win + $urandom_range(0, 100000));
        slew = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 100000))
                                           : CFG_DATA_W'($urandom_range(0, 5000));
        apply_setup(period, soft_win, hard, slew);
      end
      no_gaps = ((i / 50) % 4 == 3);
      send_random_batch();
    end
    no_gaps = 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    stamp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        stamp_ch.ready = 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        stamp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      stamp_ch.ready = 1'b1;
      do @(posedge clk); while (!stamp_ch.valid && hold_off_cycles == 0);
    end
  end

  always @(posedge clk) begin
    batch_stamp_t want;
    if (!rst && stamp_ch.valid && stamp_ch.ready) begin
      stamps_checked++;
      mode_seen[stamp_ch.lock_mode]++;
      if (pending_stamps.size() == 0) begin
        note_mismatch("stamp with no request", '0, 64'(stamp_ch.base_time_us));
      end else begin
        want = pending_stamps.pop_front();
        if (stamp_ch.base_time_us !== want.base) begin
          note_mismatch("base_time_us", 64'(want.base), 64'(stamp_ch.base_time_us));
        end
        if (stamp_ch.lock_mode !== want.mode) begin
          note_mismatch("lock_mode", 64'(want.mode), 64'(stamp_ch.lock_mode));
        end
        if (stamp_ch.phase_err !== want.err) begin
          note_mismatch("phase_err", 64'(want.err), 64'(stamp_ch.phase_err));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (batch_ch.valid && batch_ch.ready) || (stamp_ch.valid && stamp_ch.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("timeout: no request or stamp moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_first_lock_and_wrap();
    test_register_extremes();
    test_output_backpressure();
    test_random_batches();
    wait_idle();
    fail_count += pending_stamps.size();
    $display("%0d batches sent, %0d stamps checked, %0d failures", requests_sent,
             stamps_checked, fail_count);
    $display("modes seen: first lock %0d, resync %0d, slew %0d, coast %0d",
             mode_seen[MODE_FIRST], mode_seen[MODE_HARD], mode_seen[MODE_SOFT],
             mode_seen[MODE_COAST]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bttp_pkg.sv
rtl/bttp_batch_if.sv
rtl/bttp_stamp_if.sv
rtl/bttp_cfg.sv
rtl/bttp_front.sv
rtl/bttp_track.sv
rtl/batch_timestamp_phase_tracker.sv
rtl/bttp_checker.sv
verif/testbench.sv
